>>> src/mce_pkg.sv
`timescale 1ns / 1ps
// mce_pkg: symbol codes, register indexes, reset values and the morse tables
// shared by the morse encoder front end, queue, back end and top level
// no dependencies
package mce_pkg;

    localparam logic [1:0] SYM_DOT  = 2'd0;
    localparam logic [1:0] SYM_DASH = 2'd1;
    localparam logic [1:0] SYM_LGAP = 2'd2;
    localparam logic [1:0] SYM_WGAP = 2'd3;

    localparam logic [1:0] REG_DOT_DURATION   = 2'd0;
    localparam logic [1:0] REG_DASH_DURATION  = 2'd1;
    localparam logic [1:0] REG_TONE_FREQUENCY = 2'd2;

    localparam logic [15:0] DOT_DURATION_RST   = 16'd100;
    localparam logic [15:0] DASH_DURATION_RST  = 16'd300;
    localparam logic [15:0] TONE_FREQUENCY_RST = 16'd850;

    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    localparam logic [2:0] DIGIT_LEN = 3'd5;

    // element count and pattern, bit k set means element k is a dash
    localparam logic [2:0] LETTER_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [4:0] LETTER_BITS [26] = '{
        5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
        5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3
    };
    localparam logic [4:0] DIGIT_BITS [10] = '{
        5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
    };

    typedef struct packed {
        logic       wgap;
        logic [2:0] len;
        logic [4:0] pattern;
    } mce_entry_t;

    typedef struct packed {
        logic       keep;
        mce_entry_t entry;
    } mce_class_t;

    typedef struct packed {
        logic [15:0] dot_duration;
        logic [15:0] dash_duration;
        logic [15:0] tone_frequency;
    } mce_cfg_t;

    function automatic mce_class_t mce_classify(input logic [7:0] c);
        mce_class_t res;
        logic [7:0] lc;
        logic [7:0] loff;
        logic [7:0] doff;
        res = '0;
        lc  = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            lc = c | CASE_BIT;
        end
        loff = lc - CHAR_LOWER_A;
        doff = c - CHAR_ZERO;
        if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_Z) begin
            res.keep          = 1'b1;
            res.entry.len     = LETTER_LEN[loff[4:0]];
            res.entry.pattern = LETTER_BITS[loff[4:0]];
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            res.keep          = 1'b1;
            res.entry.len     = DIGIT_LEN;
            res.entry.pattern = DIGIT_BITS[doff[3:0]];
        end else if (c == CHAR_SPACE) begin
            res.keep       = 1'b1;
            res.entry.wgap = 1'b1;
        end
        return res;
    endfunction

endpackage

>>> src/mce_front.sv
`timescale 1ns / 1ps
// mce_front: accepts characters, classifies them and drops the ignored ones
// depends on mce_pkg
module mce_front
    import mce_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    output logic       push_valid,
    input  logic       push_ready,
    output mce_entry_t push_entry
);

    logic       valid_reg;
    logic       valid_next;
    mce_entry_t entry_reg;
    mce_class_t cls;
    logic       accept;

    assign cls     = mce_classify(s_char_code);
    assign s_ready = !valid_reg || push_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg && !push_ready;
        if (accept && cls.keep) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            entry_reg <= cls.entry;
        end
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule

>>> src/mce_queue.sv
`timescale 1ns / 1ps
// mce_queue: small fifo of classified characters between front and back end
// depends on mce_pkg
module mce_queue
    import mce_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  mce_entry_t push_entry,
    output logic       head_valid,
    input  logic       pop,
    output mce_entry_t head_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    mce_entry_t    entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;
    assign head_entry = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> src/mce_back.sv
`timescale 1ns / 1ps
// mce_back: walks the elements of the queue head and drives the output register
// depends on mce_pkg
module mce_back
    import mce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  mce_cfg_t    cfg,
    input  logic        head_valid,
    input  mce_entry_t  head_entry,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_symbol,
    output logic [15:0] m_duration,
    output logic [15:0] m_tone,
    output logic        m_last
);

    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic        valid_reg;
    logic        valid_next;
    logic [1:0]  symbol_reg;
    logic [15:0] duration_reg;
    logic [15:0] tone_reg;
    logic        last_reg;
    logic [1:0]  sym_c;
    logic [15:0] dur_c;
    logic [15:0] tone_c;
    logic        last_c;
    logic        load_ok;
    logic        take;

    assign load_ok = !valid_reg || m_ready;
    assign take    = head_valid && load_ok;
    assign pop     = take && last_c;

    always_comb begin
        sym_c  = SYM_DOT;
        dur_c  = '0;
        tone_c = '0;
        last_c = 1'b1;
        if (head_entry.wgap) begin
            sym_c = SYM_WGAP;
        end else if (idx_reg >= head_entry.len) begin
            sym_c = SYM_LGAP;
        end else begin
            last_c = 1'b0;
            tone_c = cfg.tone_frequency;
            if (head_entry.pattern[idx_reg]) begin
                sym_c = SYM_DASH;
                dur_c = cfg.dash_duration;
            end else begin
                sym_c = SYM_DOT;
                dur_c = cfg.dot_duration;
            end
        end
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_ready;
        if (take) begin
            valid_next = 1'b1;
            idx_next   = last_c ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            symbol_reg   <= sym_c;
            duration_reg <= dur_c;
            tone_reg     <= tone_c;
            last_reg     <= last_c;
        end
    end

    assign m_valid    = valid_reg;
    assign m_symbol   = symbol_reg;
    assign m_duration = duration_reg;
    assign m_tone     = tone_reg;
    assign m_last     = last_reg;

endmodule

>>> src/morse_code_encoder_unit.sv
`timescale 1ns / 1ps
// morse_code_encoder_unit: top level of the morse encoder, config registers
// depends on mce_pkg, mce_front, mce_queue, mce_back
//
// channel  dir  request moves                       handshake
// s_       in   one character s_char_code           s_valid / s_ready
// m_       out  one symbol with duration, tone, last m_valid / m_ready
// cfg_     in   register index and 16-bit data      cfg_valid / cfg_ready
//
// one result per cycle from the output register while m_ready is high: a letter or
// digit gives len + 1 results (2 to 6), a space one, an ignored character none
// characters are taken one per cycle while the queue has room
// a taken request passes the front end register, the queue and the output register
// aresetn is synchronous; it empties the queue and loads the default registers
// cfg_ready is always high
module morse_code_encoder_unit
    import mce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_symbol,
    output logic [15:0] m_duration,
    output logic [15:0] m_tone,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    mce_cfg_t   cfg_reg;
    mce_cfg_t   cfg_next;
    logic       push_valid;
    logic       push_ready;
    mce_entry_t push_entry;
    logic       head_valid;
    mce_entry_t head_entry;
    logic       pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DOT_DURATION:   cfg_next.dot_duration   = cfg_data;
                REG_DASH_DURATION:  cfg_next.dash_duration  = cfg_data;
                REG_TONE_FREQUENCY: cfg_next.tone_frequency = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dot_duration   <= DOT_DURATION_RST;
            cfg_reg.dash_duration  <= DASH_DURATION_RST;
            cfg_reg.tone_frequency <= TONE_FREQUENCY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mce_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    mce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .head_entry (head_entry)
    );

    mce_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_symbol   (m_symbol),
        .m_duration (m_duration),
        .m_tone     (m_tone),
        .m_last     (m_last)
    );

    // gaps close a character and carry no tone
    a_gap_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_symbol == SYM_LGAP || m_symbol == SYM_WGAP)
        |-> m_last && m_duration == '0 && m_tone == '0)
        else $error("gap result with tone or without last");

    // tone elements are never the final result of a character
    a_elem_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_symbol == SYM_DOT || m_symbol == SYM_DASH)
        |-> !m_last && m_tone == cfg_reg.tone_frequency)
        else $error("tone element flagged last or wrong tone");

    // dot durations follow the configured dot length
    a_elem_duration: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_symbol == SYM_DOT |-> m_duration == cfg_reg.dot_duration)
        else $error("dot duration mismatch");

    // a word gap is a character of its own, so it follows a last result
    a_wgap_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_symbol != SYM_WGAP)
        else $error("character sequence broken");

endmodule

>>> dv/tb_morse_code_encoder_unit.sv
`timescale 1ns / 1ps
// tb_morse_code_encoder_unit: self-checking testbench for the morse encoder top level
// predicts every symbol from its own copy of the registers and the itu table
// depends on mce_pkg and morse_code_encoder_unit
module tb_morse_code_encoder_unit;
    import mce_pkg::*;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         DRAIN_WAIT  = 12;
    localparam int         CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]  symbol;
        logic [15:0] duration;
        logic [15:0] tone;
        logic        last;
        logic [7:0]  char_code;
    } morse_sym_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_code;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_symbol;
    logic [15:0] m_duration;
    logic [15:0] m_tone;
    logic        m_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    morse_sym_t  pending_symbols [$];
    logic [15:0] dot_len_q;
    logic [15:0] dash_len_q;
    logic [15:0] tone_hz_q;

    bit tx_steady;
    bit rx_steady;
    int rx_hold_cycles;
    int cycle_count;
    int n_chars;
    int n_symbols;
    int n_writes;
    int n_errors;

    morse_code_encoder_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_symbol    (m_symbol),
        .m_duration  (m_duration),
        .m_tone      (m_tone),
        .m_last      (m_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d symbols outstanding", $time, pending_symbols.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // itu patterns, lower-case letters and digits
    function automatic string itu_pattern(input logic [7:0] lc);
        case (lc)
            "a": return ".-";
            "b": return "-...";
            "c": return "-.-.";
            "d": return "-..";
            "e": return ".";
            "f": return "..-.";
            "g": return "--.";
            "h": return "....";
            "i": return "..";
            "j": return ".---";
            "k": return "-.-";
            "l": return ".-..";
            "m": return "--";
            "n": return "-.";
            "o": return "---";
            "p": return ".--.";
            "q": return "--.-";
            "r": return ".-.";
            "s": return "...";
            "t": return "-";
            "u": return "..-";
            "v": return "...-";
            "w": return ".--";
            "x": return "-..-";
            "y": return "-.--";
            "z": return "--..";
            "0": return "-----";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    function automatic void push_symbol(input logic [1:0] sym, input logic [15:0] dur,
                                        input logic [15:0] hz, input logic fin,
                                        input logic [7:0] c);
        morse_sym_t s;
        s.symbol    = sym;
        s.duration  = dur;
        s.tone      = hz;
        s.last      = fin;
        s.char_code = c;
        pending_symbols.push_back(s);
    endfunction

    function automatic void encode_char(input logic [7:0] c);
        logic [7:0] lc;
        string      code;
        lc = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            lc = c | CASE_BIT;
        end
        code = itu_pattern(lc);
        if (code.len() > 0) begin
            for (int k = 0; k < code.len(); k++) begin
                if (code[k] == "-") begin
                    push_symbol(SYM_DASH, dash_len_q, tone_hz_q, 1'b0, c);
                end else begin
                    push_symbol(SYM_DOT, dot_len_q, tone_hz_q, 1'b0, c);
                end
            end
            push_symbol(SYM_LGAP, 16'd0, 16'd0, 1'b1, c);
        end else if (c == CHAR_SPACE) begin
            push_symbol(SYM_WGAP, 16'd0, 16'd0, 1'b1, c);
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return CHAR_UPPER_A + 8'($urandom_range(0, 25));
        if (r < 60) return CHAR_LOWER_A + 8'($urandom_range(0, 25));
        if (r < 75) return CHAR_ZERO + 8'($urandom_range(0, 9));
        if (r < 85) return CHAR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_reg_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd1;
        if (r == 1) return 16'hffff;
        return 16'($urandom_range(1, 65535));
    endfunction

    // result checker
    always @(posedge aclk) begin
        morse_sym_t want;
        if (aresetn && m_valid && m_ready) begin
            n_symbols++;
            if (pending_symbols.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected symbol %0d duration %0d tone %0d last %0b",
                         $time, m_symbol, m_duration, m_tone, m_last);
            end else begin
                want = pending_symbols.pop_front();
                if (m_symbol !== want.symbol) begin
                    n_errors++;
                    $display("%0t: char 0x%02h symbol expected %0d actual %0d",
                             $time, want.char_code, want.symbol, m_symbol);
                end
                if (m_duration !== want.duration) begin
                    n_errors++;
                    $display("%0t: char 0x%02h duration expected %0d actual %0d",
                             $time, want.char_code, want.duration, m_duration);
                end
                if (m_tone !== want.tone) begin
                    n_errors++;
                    $display("%0t: char 0x%02h tone expected %0d actual %0d",
                             $time, want.char_code, want.tone, m_tone);
                end
                if (m_last !== want.last) begin
                    n_errors++;
                    $display("%0t: char 0x%02h last expected %0b actual %0b",
                             $time, want.char_code, want.last, m_last);
                end
            end
        end
    end

    // result side ready, with random stalls and an optional long hold
    initial begin : rx_side
        int  left;
        bit  ready_phase;
        left        = 0;
        ready_phase = 1'b1;
        m_ready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready = 1'b0;
                rx_hold_cycles--;
            end else if (rx_steady) begin
                m_ready = 1'b1;
            end else begin
                if (left == 0) begin
                    ready_phase = ($urandom_range(0, 99) < 65);
                    left = ready_phase ? $urandom_range(1, 8) : 1 + idle_len();
                end
                m_ready = ready_phase;
                left--;
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid     = 1'b0;
            s_char_code = 8'($urandom_range(0, 255));
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     = 1'b1;
        s_char_code = c;
        do @(posedge aclk); while (!s_ready);
        encode_char(c);
        n_chars++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_symbols.size() != 0) @(posedge aclk);
        // ignored characters are dropped in the front end and never enter the queue
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DOT_DURATION:   dot_len_q  = value;
            REG_DASH_DURATION:  dash_len_q = value;
            REG_TONE_FREQUENCY: tone_hz_q  = value;
            default: ;
        endcase
        n_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i]);
        end
    endtask

    // reset values, every symbol kind and the class boundaries
    task automatic test_reset_defaults();
        send_text("AzE T09");
        send_char(8'h00);
        send_char(8'hff);
        send_char(8'h80);
        send_char(8'h7f);
        send_text("@[`{/:");
        send_text("QjY5");
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_DOT_DURATION, 16'hffff);
        write_reg(REG_DASH_DURATION, 16'hffff);
        write_reg(REG_TONE_FREQUENCY, 16'hffff);
        send_text("Kp8 ");
        wait_drained();
        write_reg(REG_DOT_DURATION, 16'd1);
        write_reg(REG_DASH_DURATION, 16'd1);
        write_reg(REG_TONE_FREQUENCY, 16'd1);
        send_text("bx");
        wait_drained();
        // zero registers pass straight through
        write_reg(REG_DOT_DURATION, 16'd0);
        write_reg(REG_DASH_DURATION, 16'd0);
        write_reg(REG_TONE_FREQUENCY, 16'd0);
        send_text("r3");
        wait_drained();
        // the unused index must leave the registers alone
        write_reg(REG_DOT_DURATION, 16'h5a5a);
        write_reg(REG_DASH_DURATION, 16'ha5a5);
        write_reg(REG_TONE_FREQUENCY, 16'h0f0f);
        write_reg(REG_UNUSED, 16'hffff);
        write_reg(REG_UNUSED, 16'h0000);
        send_text("Vc");
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (40) send_char(pick_char());
        wait_drained();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_output_backpressure();
        tx_steady      = 1'b1;
        rx_hold_cycles = 300;
        send_text("HELLO WORLD 0987");
        tx_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (10) send_char(pick_char());
        wait_drained();
        repeat (10) send_char(pick_char());
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(REG_DOT_DURATION, pick_reg_value());
            write_reg(REG_DASH_DURATION, pick_reg_value());
            write_reg(REG_TONE_FREQUENCY, pick_reg_value());
            repeat (45) send_char(pick_char());
            wait_drained();
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_char_code    = 8'd0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_DOT_DURATION;
        cfg_data       = 16'd0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        rx_hold_cycles = 0;
        cycle_count    = 0;
        n_chars        = 0;
        n_symbols      = 0;
        n_writes       = 0;
        n_errors       = 0;
        dot_len_q      = DOT_DURATION_RST;
        dash_len_q     = DASH_DURATION_RST;
        tone_hz_q      = TONE_FREQUENCY_RST;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_back_to_back();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();
        wait_drained();

        $display("sent %0d characters and checked %0d symbols over %0d register writes,",
                 n_chars, n_symbols, n_writes);
        $display("including a long output hold, zero and full-scale registers");
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> files.f
src/mce_pkg.sv
src/mce_front.sv
src/mce_queue.sv
src/mce_back.sv
src/morse_code_encoder_unit.sv
dv/tb_morse_code_encoder_unit.sv
